FILE: sv/mfc_pkg.sv
// ============================================================================
// mfc_pkg: multichannel FIR convolver shared definitions
// Types, sizes, register codes and helpers for the FIR core and its RAMs.
// ============================================================================
`default_nettype none

package mfc_pkg;

   // Sizing
   localparam int MAX_TAPS     = 512;
   localparam int MAX_CHANNELS = 2;
   localparam int SAMPLE_BITS  = 24;

   localparam int FRAC_BITS  = SAMPLE_BITS - 1;
   localparam int PTR_BITS   = $clog2(MAX_TAPS);
   localparam int TAP_BITS   = $clog2(MAX_TAPS + 1);
   localparam int CNT_BITS   = $clog2(MAX_CHANNELS + 1);
   localparam int CH_IDX_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int MEM_DEPTH  = MAX_CHANNELS * MAX_TAPS;
   localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
   localparam int PROD_BITS  = 2 * SAMPLE_BITS;
   localparam int ACC_BITS   = (PROD_BITS + PTR_BITS > 64) ? 64 : PROD_BITS + PTR_BITS;

   // Field widths
   localparam int CHAN_BITS      = 1;
   localparam int TAP_IDX_BITS   = 9;
   localparam int TAP_COUNT_BITS = 10;
   localparam int CH_COUNT_BITS  = 2;

   // Saturation limits
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Register reset values
   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET     = TAP_COUNT_BITS'(512);
   localparam logic [CH_COUNT_BITS-1:0]  CHANNEL_COUNT_RESET = CH_COUNT_BITS'(2);
   localparam logic                      TRIM_CENTER_RESET   = 1'b1;

   // APB register map
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_TAP_COUNT     = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_TRIM_CENTER   = 2'd2;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_FLUSH  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      action_type                     action;
      logic [CHAN_BITS-1:0]           channel;
      logic [TAP_IDX_BITS-1:0]        tap_index;
      logic signed [SAMPLE_BITS-1:0]  value;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]           out_channel;
      logic signed [SAMPLE_BITS-1:0]  out_sample;
      logic                           clipped;
   } rsp_payload_type;

   // Zero acts as one, above MAX_TAPS clamps.
   function automatic logic [TAP_BITS-1:0] eff_taps(input logic [TAP_COUNT_BITS-1:0] tc);
      int t;
      t = int'(tc);
      if (t == 0) t = 1;
      else if (t > MAX_TAPS) t = MAX_TAPS;
      return TAP_BITS'(t);
   endfunction

   function automatic logic [CNT_BITS-1:0] eff_chans(input logic [CH_COUNT_BITS-1:0] cc);
      int c;
      c = int'(cc);
      if (c == 0) c = 1;
      else if (c > MAX_CHANNELS) c = MAX_CHANNELS;
      return CNT_BITS'(c);
   endfunction

   // Flat RAM address of (channel, tap slot).
   function automatic logic [ADDR_BITS-1:0] mem_addr(input logic [CHAN_BITS-1:0] ch,
                                                     input logic [PTR_BITS-1:0] idx);
      return ADDR_BITS'(int'(ch) * MAX_TAPS + int'(idx));
   endfunction

endpackage

`default_nettype wire

FILE: sv/mfc_ram.sv
// ============================================================================
// mfc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module mfc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/multichannel_fir_convolver_core.sv
// ============================================================================
// multichannel_fir_convolver_core: per-channel direct-form FIR, Q1.23
// Coefficient and history RAMs, one MAC per tap per cycle, saturating output.
// ============================================================================
//
//   channel  ports              direction  beat carries
//   -------  -----------------  ---------  ------------------------------------
//   req      req_valid/ready    in         action, channel, tap_index, value
//   rsp      rsp_valid/ready    out        out_channel, out_sample, clipped
//   csr      psel..pready APB   in/out     tap_count, channel_count, trim_center
//
// A sample or flush beat is accepted and writes history, then the coefficient
// and history RAMs are read one tap per cycle on the single read port of each
// RAM, the pipeline multiplies and accumulates, and a last step saturates and
// loads the output register. Load and clear beats complete without leaving
// idle. Reset is synchronous, active high; no clearing pass runs: a
// per-channel fill count masks history never written. A full output register
// only stalls the core at the end of the next untrimmed sample or flush.
// ============================================================================
`default_nettype none

module multichannel_fir_convolver_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire mfc_pkg::req_payload_type             req_payload,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output mfc_pkg::rsp_payload_type                  rsp_payload,
   // APB configuration
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [mfc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [mfc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [mfc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                      pready
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [mfc_pkg::TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [mfc_pkg::CH_COUNT_BITS-1:0]  channel_count_ff;
   logic                               trim_center_ff;
   logic                               csr_write;
   logic [1:0]                         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[mfc_pkg::CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= mfc_pkg::TAP_COUNT_RESET;
         channel_count_ff <= mfc_pkg::CHANNEL_COUNT_RESET;
         trim_center_ff   <= mfc_pkg::TRIM_CENTER_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            mfc_pkg::REG_TAP_COUNT:
               tap_count_ff <= pwdata[mfc_pkg::TAP_COUNT_BITS-1:0];
            mfc_pkg::REG_CHANNEL_COUNT:
               channel_count_ff <= pwdata[mfc_pkg::CH_COUNT_BITS-1:0];
            mfc_pkg::REG_TRIM_CENTER:
               trim_center_ff <= pwdata[0];
            default: ;  // unmapped: write ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mfc_pkg::REG_TAP_COUNT:     prdata = mfc_pkg::CSR_DATA_BITS'(tap_count_ff);
         mfc_pkg::REG_CHANNEL_COUNT: prdata = mfc_pkg::CSR_DATA_BITS'(channel_count_ff);
         mfc_pkg::REG_TRIM_CENTER:   prdata = mfc_pkg::CSR_DATA_BITS'(trim_center_ff);
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // State and per-channel bookkeeping
   // ------------------------------------------------------------------------
   mfc_pkg::state_type state_ff, state_in;

   // Newest history slot and samples seen since clear (saturates at MAX_TAPS).
   // fill also drives the trim decision: count before the beat < taps/2.
   logic [mfc_pkg::PTR_BITS-1:0] ptr_ff  [mfc_pkg::MAX_CHANNELS];
   logic [mfc_pkg::TAP_BITS-1:0] fill_ff [mfc_pkg::MAX_CHANNELS];

   // Latched beat context for the MAC run
   logic [mfc_pkg::CHAN_BITS-1:0] ch_ff;
   logic [mfc_pkg::TAP_BITS-1:0]  taps_ff;
   logic [mfc_pkg::TAP_BITS-1:0]  fill_cur_ff;
   logic                          drop_ff;
   logic [mfc_pkg::PTR_BITS-1:0]  k_ff, k_in;
   logic [mfc_pkg::PTR_BITS-1:0]  hidx_ff, hidx_in;

   // MAC pipeline
   logic                                  s1_valid_ff, s1_hv_ff, s2_valid_ff;
   logic signed [mfc_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [mfc_pkg::ACC_BITS-1:0]   acc_ff;

   // Output register
   logic                     rsp_valid_ff;
   mfc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Decode of the incoming beat
   logic                              req_fire;
   logic [mfc_pkg::TAP_BITS-1:0]      taps_eff;
   logic [mfc_pkg::CNT_BITS-1:0]      chans_eff;
   logic                              ch_in_use;
   logic                              tap_ok;
   logic [mfc_pkg::CH_IDX_BITS-1:0]   cur_idx;
   logic [mfc_pkg::PTR_BITS-1:0]      cur_ptr, next_ptr;
   logic [mfc_pkg::TAP_BITS-1:0]      cur_fill, next_fill;
   logic                              drop;

   // Control from the sequencer
   logic start, clear, issue, load_rsp;
   logic coef_we, hist_we;

   // RAM ports
   logic [mfc_pkg::ADDR_BITS-1:0]     coef_waddr, coef_raddr, hist_waddr, hist_raddr;
   logic [mfc_pkg::SAMPLE_BITS-1:0]   coef_rdata, hist_rdata, hist_wdata;

   assign req_ready = (state_ff == mfc_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign taps_eff  = mfc_pkg::eff_taps(tap_count_ff);
   assign chans_eff = mfc_pkg::eff_chans(channel_count_ff);
   assign ch_in_use = mfc_pkg::CNT_BITS'(req_payload.channel) < chans_eff;
   assign tap_ok    = int'(req_payload.tap_index) < mfc_pkg::MAX_TAPS;
   assign cur_idx   = mfc_pkg::CH_IDX_BITS'(req_payload.channel);
   assign cur_ptr   = ptr_ff[cur_idx];
   assign cur_fill  = fill_ff[cur_idx];
   assign next_ptr  = (cur_ptr == mfc_pkg::PTR_BITS'(mfc_pkg::MAX_TAPS - 1)) ?
                      '0 : cur_ptr + 1'b1;
   assign next_fill = (cur_fill == mfc_pkg::TAP_BITS'(mfc_pkg::MAX_TAPS)) ?
                      cur_fill : cur_fill + 1'b1;
   assign drop      = trim_center_ff && (cur_fill < (taps_eff >> 1));

   assign coef_waddr = mfc_pkg::mem_addr(req_payload.channel,
                                         mfc_pkg::PTR_BITS'(req_payload.tap_index));
   assign hist_waddr = mfc_pkg::mem_addr(req_payload.channel, next_ptr);
   assign hist_wdata = (req_payload.action == mfc_pkg::ACT_FLUSH) ? '0 : req_payload.value;
   assign coef_raddr = mfc_pkg::mem_addr(ch_ff, k_ff);
   assign hist_raddr = mfc_pkg::mem_addr(ch_ff, hidx_ff);

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      clear    = 1'b0;
      issue    = 1'b0;
      load_rsp = 1'b0;
      coef_we  = 1'b0;
      hist_we  = 1'b0;
      k_in     = k_ff;
      hidx_in  = hidx_ff;
      unique case (state_ff)
         mfc_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.action)
                  mfc_pkg::ACT_LOAD: begin
                     coef_we = ch_in_use && tap_ok;
                  end
                  mfc_pkg::ACT_SAMPLE, mfc_pkg::ACT_FLUSH: begin
                     if (ch_in_use) begin
                        hist_we  = 1'b1;
                        start    = 1'b1;
                        k_in     = '0;
                        hidx_in  = next_ptr;
                        state_in = mfc_pkg::ST_MAC;
                     end
                  end
                  mfc_pkg::ACT_CLEAR: begin
                     clear = 1'b1;
                  end
               endcase
            end
         end
         mfc_pkg::ST_MAC: begin
            // One tap per cycle; history walks backward from the newest slot
            issue   = 1'b1;
            k_in    = k_ff + 1'b1;
            hidx_in = (hidx_ff == '0) ? mfc_pkg::PTR_BITS'(mfc_pkg::MAX_TAPS - 1) :
                      hidx_ff - 1'b1;
            if (mfc_pkg::TAP_BITS'(k_ff) == taps_ff - 1'b1) begin
               state_in = mfc_pkg::ST_FINISH;
            end
         end
         mfc_pkg::ST_FINISH: begin
            // Wait for drain, then for a free output register unless trimmed
            if (!s1_valid_ff && !s2_valid_ff) begin
               if (drop_ff) begin
                  state_in = mfc_pkg::ST_IDLE;
               end else if (!rsp_valid_ff || rsp_ready) begin
                  load_rsp = 1'b1;
                  state_in = mfc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mfc_pkg::ST_IDLE;
      endcase
   end

   // Per-channel pointer and fill count
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int c = 0; c < mfc_pkg::MAX_CHANNELS; c++) begin
            ptr_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
      end else if (start) begin
         ptr_ff[cur_idx]  <= next_ptr;
         fill_ff[cur_idx] <= next_fill;
      end
   end

   // Beat context and walk counters (payload, no reset)
   always_ff @(posedge clock) begin
      if (start) begin
         ch_ff       <= req_payload.channel;
         taps_ff     <= taps_eff;
         fill_cur_ff <= next_fill;
         drop_ff     <= drop;
      end
      k_ff    <= k_in;
      hidx_ff <= hidx_in;
   end

   // ------------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------------
   mfc_ram #(
      .WIDTH (mfc_pkg::SAMPLE_BITS),
      .DEPTH (mfc_pkg::MEM_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_payload.value),
      .rd_en   (issue),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   mfc_ram #(
      .WIDTH (mfc_pkg::SAMPLE_BITS),
      .DEPTH (mfc_pkg::MEM_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (issue),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   // ------------------------------------------------------------------------
   // MAC pipeline: read -> multiply -> accumulate
   // ------------------------------------------------------------------------
   logic signed [mfc_pkg::SAMPLE_BITS-1:0] coef_op, hist_op;

   assign coef_op = coef_rdata;
   // slots not written since clear read as zero
   assign hist_op = s1_hv_ff ? hist_rdata : '0;
   assign prod_in = coef_op * hist_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hv_ff <= mfc_pkg::TAP_BITS'(k_ff) < fill_cur_ff;
      prod_ff  <= prod_in;
      if (start) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + mfc_pkg::ACC_BITS'(prod_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Shift by FRAC_BITS and saturate; clip when bits above the result
   // window disagree with the sign.
   // ------------------------------------------------------------------------
   localparam int TOP = mfc_pkg::FRAC_BITS + mfc_pkg::SAMPLE_BITS - 1;

   logic [mfc_pkg::ACC_BITS-TOP-1:0] acc_upper;
   logic                             fits;

   assign acc_upper = acc_ff[mfc_pkg::ACC_BITS-1:TOP];
   assign fits      = (&acc_upper) || !(|acc_upper);

   always_comb begin
      rsp_payload_in.out_channel = ch_ff;
      rsp_payload_in.clipped     = !fits;
      if (fits) begin
         rsp_payload_in.out_sample = acc_ff[TOP:mfc_pkg::FRAC_BITS];
      end else if (acc_ff[mfc_pkg::ACC_BITS-1]) begin
         rsp_payload_in.out_sample = mfc_pkg::SAT_MIN;
      end else begin
         rsp_payload_in.out_sample = mfc_pkg::SAT_MAX;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   a_pipe_in_run: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |->
         (state_ff == mfc_pkg::ST_MAC || state_ff == mfc_pkg::ST_FINISH))
      else $error("MAC pipeline busy outside a sample run");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == mfc_pkg::ST_FINISH)
      else $error("response raised outside finish");

   a_tap_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfc_pkg::ST_MAC) |-> (mfc_pkg::TAP_BITS'(k_ff) < taps_ff))
      else $error("tap walk ran past tap count");

   a_no_pending_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("beat accepted with MAC pipeline busy");
`endif

endmodule

`default_nettype wire

FILE: bench/fir_result_checker.sv
// ============================================================================
// fir_result_checker: result predictor and comparator for the FIR core
// Watches request, response and APB write beats, keeps its own copy of the
// filter state and compares every response beat with the oldest prediction.
// ============================================================================
`default_nettype none

module fir_result_checker
   import mfc_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire req_payload_type               req_payload,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire rsp_payload_type               rsp_payload,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic                          pready,
   input  wire logic [CSR_ADDR_BITS-1:0]      paddr,
   input  wire logic [CSR_DATA_BITS-1:0]      pwdata,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 compared_count,
   output int                                 clipped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow registers
   logic [TAP_COUNT_BITS-1:0]      cfg_taps;
   logic [CH_COUNT_BITS-1:0]       cfg_chans;
   logic                           cfg_trim;

   // shadow filter state
   logic signed [SAMPLE_BITS-1:0]  coef_mem [MAX_CHANNELS][MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0]  hist_mem [MAX_CHANNELS][MAX_TAPS];
   logic [PTR_BITS-1:0]            newest   [MAX_CHANNELS];
   int unsigned                    outputs_seen [MAX_CHANNELS];

   rsp_payload_type                filtered_q [$];
   int                             errors;
   int                             compared;
   int                             clipped_seen;

   function automatic void clear_history();
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         for (int t = 0; t < MAX_TAPS; t++) hist_mem[c][t] = '0;
         newest[c]       = '0;
         outputs_seen[c] = 0;
      end
   endfunction

   // Applies one request beat to the shadow state; returns 1 when it yields
   // a filtered sample.
   function automatic bit convolve_item(input req_payload_type item,
                                        output rsp_payload_type res);
      int unsigned                   taps;
      int unsigned                   chans;
      int                            k;
      logic [PTR_BITS-1:0]           p;
      logic signed [SAMPLE_BITS-1:0] x;
      longint                        acc;
      longint                        scaled;
      bit                            clip;
      bit                            drop;
      res = '0;
      if (item.action == ACT_CLEAR) begin
         clear_history();
         return 1'b0;
      end
      chans = (cfg_chans == 0) ? 1 : ((cfg_chans > MAX_CHANNELS) ? MAX_CHANNELS : cfg_chans);
      if (item.channel >= chans) return 1'b0;
      if (item.action == ACT_LOAD) begin
         coef_mem[item.channel][item.tap_index] = item.value;
         return 1'b0;
      end
      x = (item.action == ACT_FLUSH) ? '0 : item.value;
      p = newest[item.channel] + 1'b1;
      newest[item.channel] = p;
      hist_mem[item.channel][p] = x;

      taps = (cfg_taps == 0) ? 1 : ((cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps);
      acc  = 0;
      for (k = 0; k < taps; k++)
         acc += longint'(coef_mem[item.channel][k])
              * longint'(hist_mem[item.channel][PTR_BITS'(int'(p) - k)]);
      scaled = acc >>> FRAC_BITS;
      clip   = 1'b0;
      if (scaled > longint'(SAT_MAX)) begin
         scaled = longint'(SAT_MAX);
         clip   = 1'b1;
      end else if (scaled < longint'(SAT_MIN)) begin
         scaled = longint'(SAT_MIN);
         clip   = 1'b1;
      end

      // trim: drop the head of each channel's convolution
      drop = cfg_trim && (outputs_seen[item.channel] < taps / 2);
      if (outputs_seen[item.channel] < MAX_TAPS / 2) outputs_seen[item.channel]++;
      if (drop) return 1'b0;

      res.out_channel = item.channel;
      res.out_sample  = scaled[SAMPLE_BITS-1:0];
      res.clipped     = clip;
      return 1'b1;
   endfunction

   function automatic void note_failure(input string what, input rsp_payload_type want,
                                        input rsp_payload_type got);
      errors++;
      if (errors <= 10)
         $display("[%0t] %s: expected ch %0d sample %0d clip %0b, got ch %0d sample %0d clip %0b",
                  $time, what, want.out_channel, $signed(want.out_sample), want.clipped,
                  got.out_channel, $signed(got.out_sample), got.clipped);
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      bit              produced;
      if (reset) begin
         cfg_taps  = TAP_COUNT_RESET;
         cfg_chans = CHANNEL_COUNT_RESET;
         cfg_trim  = TRIM_CENTER_RESET;
         clear_history();
         filtered_q.delete();
         errors       = 0;
         compared     = 0;
         clipped_seen = 0;
      end else begin
         // response first: it can only belong to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (filtered_q.size() == 0) begin
               note_failure("response beat with nothing pending", '0, rsp_payload);
            end else begin
               want = filtered_q.pop_front();
               compared++;
               if (want.clipped) clipped_seen++;
               if (rsp_payload.out_channel !== want.out_channel
                   || rsp_payload.out_sample !== want.out_sample
                   || rsp_payload.clipped !== want.clipped)
                  note_failure("response mismatch", want, rsp_payload);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_BITS-1:2])
               REG_TAP_COUNT:     cfg_taps  = pwdata[TAP_COUNT_BITS-1:0];
               REG_CHANNEL_COUNT: cfg_chans = pwdata[CH_COUNT_BITS-1:0];
               REG_TRIM_CENTER:   cfg_trim  = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            produced = convolve_item(req_payload, want);
            if (produced) filtered_q.push_back(want);
         end
      end
      fail_count     <= errors;
      pending_count  <= filtered_q.size();
      compared_count <= compared;
      clipped_count  <= clipped_seen;
   end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ============================================================================
// tb_top: stimulus and verdict for multichannel_fir_convolver_core
// Directed corner beats, then twelve randomized phases over tap, channel and
// trim settings with varying backpressure; a side checker does the scoring.
// ============================================================================
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mfc_pkg::*;

   // Drain time after the last expected result: a trimmed beat may still be
   // in the MAC loop.
   localparam int SETTLE_CYCLES = MAX_TAPS + 16;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            psel        = 1'b0;
   logic            penable     = 1'b0;
   logic            pwrite      = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr  = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic            pready;

   int fail_count;
   int pending_count;
   int compared_count;
   int clipped_count;

   // stimulus bookkeeping
   int                        send_idle_pct = 0;  // chance per cycle the sender holds off
   int                        stall_pct     = 0;  // chance per cycle rsp_ready is low
   int                        beats_sent    = 0;
   int                        settings_used = 0;
   logic [TAP_COUNT_BITS-1:0] cur_taps      = TAP_COUNT_RESET;
   logic [CH_COUNT_BITS-1:0]  cur_chans     = CHANNEL_COUNT_RESET;
   bit                        coef_loaded [MAX_CHANNELS][MAX_TAPS];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   multichannel_fir_convolver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   fir_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .compared_count (compared_count),
      .clipped_count  (clipped_count)
   );

   // Receiver backpressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Effective settings as the core sees them (zero and overrange clamp).
   function automatic int chans_in_use();
      if (cur_chans == 0) return 1;
      if (cur_chans > MAX_CHANNELS) return MAX_CHANNELS;
      return int'(cur_chans);
   endfunction

   function automatic int taps_in_use();
      if (cur_taps == 0) return 1;
      if (cur_taps > MAX_TAPS) return MAX_TAPS;
      return int'(cur_taps);
   endfunction

   // Full-scale extremes, small values around zero, and anything at all.
   function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // Coefficients are often scaled down so long filters don't always clip.
   function automatic logic signed [SAMPLE_BITS-1:0] coef_value();
      return rand_value() >>> $urandom_range(0, 8);
   endfunction

   // One request beat. Valid stays high across back-to-back beats; it only
   // drops when the sender decides to idle or the core is drained.
   task automatic push_beat(input action_type act, input logic [CHAN_BITS-1:0] ch,
                            input logic [TAP_IDX_BITS-1:0] idx,
                            input logic signed [SAMPLE_BITS-1:0] val);
      req_payload_type beat;
      beat.action    = act;
      beat.channel   = ch;
      beat.tap_index = idx;
      beat.value     = val;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (act == ACT_LOAD && ch < chans_in_use()) coef_loaded[ch][idx] = 1'b1;
   endtask

   // Sample or flush; first loads any coefficient the filter would read that
   // has never been written, since those taps hold no defined value.
   task automatic sample_beat(input action_type act, input logic [CHAN_BITS-1:0] ch,
                              input logic signed [SAMPLE_BITS-1:0] val);
      if (ch < chans_in_use()) begin
         for (int k = 0; k < taps_in_use(); k++)
            if (!coef_loaded[ch][k]) push_beat(ACT_LOAD, ch, TAP_IDX_BITS'(k), coef_value());
      end
      push_beat(act, ch, TAP_IDX_BITS'($urandom_range(0, MAX_TAPS - 1)), val);
   endtask

   // Wait for every predicted result, then for any trimmed beat in the MAC loop.
   task automatic drain_core();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready.
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TAP_COUNT:     cur_taps  = data[TAP_COUNT_BITS-1:0];
         REG_CHANNEL_COUNT: cur_chans = data[CH_COUNT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int taps, input int chans, input bit trim);
      drain_core();
      write_reg(REG_TAP_COUNT, CSR_DATA_BITS'(taps));
      write_reg(REG_CHANNEL_COUNT, CSR_DATA_BITS'(chans));
      write_reg(REG_TRIM_CENTER, CSR_DATA_BITS'(trim));
      settings_used++;
   endtask

   // Mostly samples and flushes on live channels, with coefficient reloads,
   // the odd clear, and beats for unused channels that the core must ignore.
   // The budget counts every beat sent, missing-coefficient loads included.
   task automatic random_phase(input int budget);
      int                   first_beat;
      int                   pick;
      logic [CHAN_BITS-1:0] ch;
      first_beat = beats_sent;
      while (beats_sent - first_beat < budget) begin
         pick = $urandom_range(0, 99);
         ch   = CHAN_BITS'($urandom_range(0, 1));
         if (pick < 55)
            sample_beat(ACT_SAMPLE, ch, rand_value());
         else if (pick < 67)
            sample_beat(ACT_FLUSH, ch, rand_value());
         else if (pick < 87)
            push_beat(ACT_LOAD, ch, TAP_IDX_BITS'($urandom_range(0, MAX_TAPS - 1)),
                      coef_value());
         else if (pick < 89)
            push_beat(ACT_CLEAR, ch, TAP_IDX_BITS'($urandom_range(0, MAX_TAPS - 1)),
                      rand_value());
         else
            // reload a tap that is actually in use
            push_beat(ACT_LOAD, ch, TAP_IDX_BITS'($urandom_range(0, taps_in_use() - 1)),
                      coef_value());
      end
   endtask

   initial begin
      int taps;
      int chans;
      int budget;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: single tap, both channels, no trim
      set_config(1, 2, 1'b0);
      push_beat(ACT_LOAD, 1'b0, '0, SAT_MAX);
      push_beat(ACT_LOAD, 1'b1, '0, SAT_MIN);
      push_beat(ACT_LOAD, 1'b0, '1, rand_value());     // top tap slot
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MAX);
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MIN);
      sample_beat(ACT_SAMPLE, 1'b1, SAT_MAX);
      sample_beat(ACT_SAMPLE, 1'b1, SAT_MIN);          // min * min saturates
      sample_beat(ACT_FLUSH, 1'b0, SAT_MIN);           // flush ignores its value
      push_beat(ACT_CLEAR, 1'b0, '0, '0);
      sample_beat(ACT_SAMPLE, 1'b1, -24'sd1);

      // ---- two taps with trim: first output per channel after a clear is dropped
      set_config(2, 2, 1'b1);
      push_beat(ACT_CLEAR, 1'b1, '0, '0);
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MAX);
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MAX);
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MIN);
      sample_beat(ACT_SAMPLE, 1'b1, rand_value());
      sample_beat(ACT_FLUSH, 1'b1, rand_value());

      // ---- zero tap count and zero channel count both act as one
      set_config(0, 0, 1'b0);
      sample_beat(ACT_SAMPLE, 1'b1, SAT_MAX);          // channel out of use
      push_beat(ACT_LOAD, 1'b1, 9'd5, SAT_MAX);        // ignored as well
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MAX);

      // ---- overrange tap count clamps to the full filter
      set_config(1023, 2, 1'b0);
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MAX);

      // ---- overrange channel count clamps to both channels
      set_config(1, 3, 1'b0);
      sample_beat(ACT_FLUSH, 1'b1, '0);
      sample_beat(ACT_SAMPLE, 1'b0, SAT_MIN);

      // ---- randomized phases; idle pattern rotates, long filters kept short
      // and on one channel so coefficient loading stays small
      for (int ph = 0; ph < 12; ph++) begin
         budget = 60;
         case (ph)
            0:  taps = 1;
            3:  begin taps = 512;  budget = 30; end
            5:  begin taps = 511;  budget = 30; end
            7:  begin taps = 1023; budget = 30; end
            9:  begin taps = 513;  budget = 30; end
            10: taps = 0;
            default: taps = $urandom_range(2, 40);
         endcase
         chans = (ph % 3 == 1 || taps > 40) ? $urandom_range(0, 1) : $urandom_range(2, 3);
         set_config(taps, chans, bit'((ph + ph / 4) % 2));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         random_phase(budget);
      end

      drain_core();
      $display("Run covered %0d request beats across %0d register settings,",
               beats_sent, settings_used);
      $display("with %0d filtered samples compared, %0d of them saturated.",
               compared_count, clipped_count);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run of this stimulus.
   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
